FILE: rtl/core/iblw_pkg.sv
// Package for the indirect block map walker core.
// Holds the item and result types, the code enums and the slot constants.
// No dependencies.
package iblw_pkg;

	localparam int DEFAULT_MAX_ENTRIES_LOG2 = 10;

	localparam int NUM_SLOTS = 15;

	localparam logic [3:0] LAST_DIRECT = 4'd11;
	localparam logic [3:0] SLOT_SINGLE = 4'd12;
	localparam logic [3:0] SLOT_DOUBLE = 4'd13;
	localparam logic [3:0] SLOT_TRIPLE = 4'd14;

	localparam logic [3:0] MIN_ENTRIES_LOG2 = 4'd8;

	typedef enum logic [1:0] {
		KIND_LOAD     = 2'd0,
		KIND_REWIND   = 2'd1,
		KIND_ADVANCE  = 2'd2,
		KIND_RESPONSE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_REQUEST    = 3'd0,
		ST_REPORT     = 3'd1,
		ST_RANGE      = 3'd2,
		ST_UNEXPECTED = 3'd3,
		ST_ACK        = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LVL_DIRECT = 2'd0,
		LVL_SINGLE = 2'd1,
		LVL_DOUBLE = 2'd2,
		LVL_TRIPLE = 2'd3
	} level_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_DATA = 2'd1,
		PEND_L1   = 2'd2,
		PEND_L2   = 2'd3
	} pend_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  ptr_index;
		logic [31:0] word;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] block_id;
		logic [9:0]  word_index;
		logic        in_file;
	} result_t;

endpackage

FILE: rtl/core/indirect_block_map_walker_core.sv
// Indirect block map walker core: inode pointer memory, walk state, two-stage datapath.
// Depends on iblw_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  item     | item_valid/stall   | item_t   (kind, ptr_index, word)
//  result   | result_valid/stall | result_t (status, block_id, word_index, in_file)
//  cfg      | cfg_valid/ready    | cfg_data (entries_log2, 4 bits)
//
// One result per item; an item can be taken every cycle while item_stall is low.
// The inode pointer memory is read into the read stage at acceptance; the result register loads from it.
// Reset (arst_n low) clears the walk state, the pointer valid bits and entries_log2 to 8.
// A stall on result holds the output register, then the read stage, then item_stall.
// cfg_ready is always high.
module indirect_block_map_walker_core
	import iblw_pkg::*;
#(
	parameter int MAX_ENTRIES_LOG2 = DEFAULT_MAX_ENTRIES_LOG2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam int IW = MAX_ENTRIES_LOG2;
	localparam logic [3:0] MAX_LG = 4'(MAX_ENTRIES_LOG2);

	// inode pointer memory with per-entry valid bits (unwritten entries read zero)
	logic [31:0]          ptr_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] ptr_vld_q;

	// walk state
	level_t       level_q;
	logic [3:0]   direct_pos_q;
	logic [IW-1:0] idx1_q, idx2_q, idx3_q;
	logic [31:0]  c1_q, c2_q;
	pend_t        pend_q;
	logic [3:0]   lg_q;

	// read stage
	logic         valid_s1;
	status_t      status_s1;
	logic         src_mem_s1;
	logic [31:0]  word_s1;
	logic [9:0]   widx_s1;
	logic         c1cmt_s1, c2cmt_s1;
	logic [31:0]  rd_s1;
	logic         rdv_s1;

	// output register
	logic         out_valid_q;
	result_t      out_q;

	logic         s1_move, accept;
	logic [3:0]   lg_eff;
	logic [IW-1:0] last_idx;
	logic [31:0]  mem_val_s1, c1_eff, c2_eff;

	// stage 0 next values
	level_t       level_n;
	logic [3:0]   direct_pos_n;
	logic [IW-1:0] idx1_n, idx2_n, idx3_n;
	logic [31:0]  c1_n, c2_n;
	pend_t        pend_n;
	status_t      status_n;
	logic         src_mem_n;
	logic [31:0]  word_n;
	logic [9:0]   widx_n;
	logic         c1cmt_n, c2cmt_n;
	logic [3:0]   raddr;
	logic         wen;

	assign cfg_ready  = 1'b1;
	assign s1_move    = !out_valid_q || !result_stall;
	assign item_stall = valid_s1 && !s1_move;
	assign accept     = item_valid && !item_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		if (lg_q < MIN_ENTRIES_LOG2) begin
			lg_eff = MIN_ENTRIES_LOG2;
		end else if (lg_q > MAX_LG) begin
			lg_eff = MAX_LG;
		end else begin
			lg_eff = lg_q;
		end
		for (int i = 0; i < IW; i++) begin
			last_idx[i] = (4'(i) < lg_eff);
		end
	end

	assign mem_val_s1 = rdv_s1 ? rd_s1 : 32'd0;
	// pointer-block ids fetched from memory land in the read stage, not the walk state: forward them
	assign c1_eff = (valid_s1 && c1cmt_s1) ? mem_val_s1 : c1_q;
	assign c2_eff = (valid_s1 && c2cmt_s1) ? mem_val_s1 : c2_q;

	always_comb begin
		level_n      = level_q;
		direct_pos_n = direct_pos_q;
		idx1_n       = idx1_q;
		idx2_n       = idx2_q;
		idx3_n       = idx3_q;
		c1_n         = c1_eff;
		c2_n         = c2_eff;
		pend_n       = pend_q;
		status_n     = ST_UNEXPECTED;
		src_mem_n    = 1'b0;
		word_n       = 32'd0;
		widx_n       = 10'd0;
		c1cmt_n      = 1'b0;
		c2cmt_n      = 1'b0;
		raddr        = 4'd0;
		wen          = 1'b0;

		unique case (item.kind)
			KIND_LOAD: begin
				if (item.ptr_index <= SLOT_TRIPLE) begin
					wen      = 1'b1;
					status_n = ST_ACK;
				end
			end
			KIND_REWIND: begin
				level_n      = LVL_DIRECT;
				direct_pos_n = 4'd0;
				idx1_n       = '0;
				idx2_n       = '0;
				idx3_n       = '0;
				c1_n         = 32'd0;
				c2_n         = 32'd0;
				pend_n       = PEND_NONE;
				status_n     = ST_REPORT;
				src_mem_n    = 1'b1;
				raddr        = 4'd0;
			end
			KIND_ADVANCE: begin
				if (pend_q != PEND_NONE) begin
					status_n = ST_UNEXPECTED;
				end else if (level_q == LVL_DIRECT) begin
					if (direct_pos_q < LAST_DIRECT) begin
						direct_pos_n = direct_pos_q + 4'd1;
						raddr        = direct_pos_q + 4'd1;
						status_n     = ST_REPORT;
						src_mem_n    = 1'b1;
					end else begin
						level_n   = LVL_SINGLE;
						idx1_n    = '0;
						raddr     = SLOT_SINGLE;
						c1cmt_n   = 1'b1;
						pend_n    = PEND_DATA;
						status_n  = ST_REQUEST;
						src_mem_n = 1'b1;
					end
				end else if (idx1_q < last_idx) begin
					idx1_n   = idx1_q + 1'b1;
					pend_n   = PEND_DATA;
					status_n = ST_REQUEST;
					word_n   = c1_eff;
					widx_n   = 10'(idx1_q + 1'b1);
				end else if (level_q == LVL_SINGLE) begin
					idx1_n    = '0;
					level_n   = LVL_DOUBLE;
					idx2_n    = '0;
					raddr     = SLOT_DOUBLE;
					c2cmt_n   = 1'b1;
					pend_n    = PEND_L1;
					status_n  = ST_REQUEST;
					src_mem_n = 1'b1;
				end else if (idx2_q < last_idx) begin
					idx1_n   = '0;
					idx2_n   = idx2_q + 1'b1;
					pend_n   = PEND_L1;
					status_n = ST_REQUEST;
					word_n   = c2_eff;
					widx_n   = 10'(idx2_q + 1'b1);
				end else if (level_q == LVL_DOUBLE) begin
					idx1_n    = '0;
					idx2_n    = '0;
					level_n   = LVL_TRIPLE;
					idx3_n    = '0;
					raddr     = SLOT_TRIPLE;
					pend_n    = PEND_L2;
					status_n  = ST_REQUEST;
					src_mem_n = 1'b1;
				end else if (idx3_q < last_idx) begin
					idx1_n    = '0;
					idx2_n    = '0;
					idx3_n    = idx3_q + 1'b1;
					raddr     = SLOT_TRIPLE;
					pend_n    = PEND_L2;
					status_n  = ST_REQUEST;
					src_mem_n = 1'b1;
					widx_n    = 10'(idx3_q + 1'b1);
				end else begin
					status_n = ST_RANGE;
				end
			end
			KIND_RESPONSE: begin
				unique case (pend_q)
					PEND_DATA: begin
						pend_n   = PEND_NONE;
						status_n = ST_REPORT;
						word_n   = item.word;
					end
					PEND_L1: begin
						c1_n     = item.word;
						pend_n   = PEND_DATA;
						status_n = ST_REQUEST;
						word_n   = item.word;
						widx_n   = 10'(idx1_q);
					end
					PEND_L2: begin
						c2_n     = item.word;
						pend_n   = PEND_L1;
						status_n = ST_REQUEST;
						word_n   = item.word;
						widx_n   = 10'(idx2_q);
					end
					PEND_NONE: begin
						status_n = ST_UNEXPECTED;
					end
				endcase
			end
		endcase
	end

	// memory array: write and registered read at item acceptance
	always_ff @(posedge clk) begin
		if (accept && wen) begin
			ptr_mem[item.ptr_index] <= item.word;
		end
		if (accept) begin
			rd_s1 <= ptr_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q <= '0;
			rdv_s1    <= 1'b0;
		end else if (accept) begin
			rdv_s1 <= ptr_vld_q[raddr];
			if (wen) begin
				ptr_vld_q[item.ptr_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= MIN_ENTRIES_LOG2;
		end else if (cfg_valid && cfg_ready) begin
			lg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= LVL_DIRECT;
			direct_pos_q <= 4'd0;
			idx1_q       <= '0;
			idx2_q       <= '0;
			idx3_q       <= '0;
			c1_q         <= 32'd0;
			c2_q         <= 32'd0;
			pend_q       <= PEND_NONE;
		end else if (accept) begin
			level_q      <= level_n;
			direct_pos_q <= direct_pos_n;
			idx1_q       <= idx1_n;
			idx2_q       <= idx2_n;
			idx3_q       <= idx3_n;
			c1_q         <= c1_n;
			c2_q         <= c2_n;
			pend_q       <= pend_n;
		end else begin
			// retire a pending cached-id fetch when no newer item overrides it
			c1_q <= c1_eff;
			c2_q <= c2_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			c1cmt_s1 <= 1'b0;
			c2cmt_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			c1cmt_s1 <= c1cmt_n;
			c2cmt_s1 <= c2cmt_n;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
			c1cmt_s1 <= 1'b0;
			c2cmt_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_n;
			src_mem_s1 <= src_mem_n;
			word_s1    <= word_n;
			widx_s1    <= widx_n;
		end
	end

	logic [31:0] id_s1;
	assign id_s1 = src_mem_s1 ? mem_val_s1 : word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			out_q.status     <= status_s1;
			out_q.block_id   <= id_s1;
			out_q.word_index <= widx_s1;
			out_q.in_file    <= (status_s1 == ST_REPORT) && (id_s1 != 32'd0);
		end
	end

endmodule

FILE: dv/indirect_block_map_walker_check.sv
// Watches the item, result and cfg channels of the block map walker core.
// It predicts each result from its own copy of the walk state and compares it field by field.
// Depends on iblw_pkg.
module indirect_block_map_walker_check
	import iblw_pkg::*;
#(
	parameter int MAX_ENTRIES_LOG2 = DEFAULT_MAX_ENTRIES_LOG2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output int          failures,
	output int          in_flight
);

	logic [31:0] inode_ptr [NUM_SLOTS];
	level_t      lvl;
	logic [3:0]  dpos;
	logic [9:0]  idx1, idx2, idx3;
	logic [31:0] blk1, blk2;
	pend_t       awaiting;
	logic [3:0]  log2_reg;

	result_t due_results [$];
	int      fail_cnt = 0;
	int      due_cnt = 0;

	assign failures = fail_cnt;
	assign in_flight = due_cnt;

	function automatic result_t pack_result(status_t st, logic [31:0] id, logic [9:0] widx);
		result_t r;
		r.status     = st;
		r.block_id   = id;
		r.word_index = (st == ST_REQUEST) ? widx : 10'd0;
		r.in_file    = (st == ST_REPORT) && (id != 32'd0);
		return r;
	endfunction

	function automatic result_t read_request(pend_t w, logic [31:0] id, logic [9:0] widx);
		awaiting = w;
		return pack_result(ST_REQUEST, id, widx);
	endfunction

	function automatic void clear_walk();
		lvl      = LVL_DIRECT;
		dpos     = '0;
		idx1     = '0;
		idx2     = '0;
		idx3     = '0;
		blk1     = '0;
		blk2     = '0;
		awaiting = PEND_NONE;
	endfunction

	function automatic result_t next_result(item_t it);
		int unsigned lg;
		int unsigned last;
		lg = log2_reg;
		if (lg < MIN_ENTRIES_LOG2) lg = MIN_ENTRIES_LOG2;
		if (lg > MAX_ENTRIES_LOG2) lg = MAX_ENTRIES_LOG2;
		last = (1 << lg) - 1;
		case (it.kind)
			KIND_LOAD: begin
				if (it.ptr_index > SLOT_TRIPLE) return pack_result(ST_UNEXPECTED, 0, 0);
				inode_ptr[it.ptr_index] = it.word;
				return pack_result(ST_ACK, 0, 0);
			end
			KIND_REWIND: begin
				clear_walk();
				return pack_result(ST_REPORT, inode_ptr[0], 0);
			end
			KIND_ADVANCE: begin
				if (awaiting != PEND_NONE) return pack_result(ST_UNEXPECTED, 0, 0);
				if (lvl == LVL_DIRECT) begin
					if (dpos < LAST_DIRECT) begin
						dpos++;
						return pack_result(ST_REPORT, inode_ptr[dpos], 0);
					end
					lvl  = LVL_SINGLE;
					idx1 = '0;
					blk1 = inode_ptr[SLOT_SINGLE];
					return read_request(PEND_DATA, blk1, 0);
				end
				if (idx1 < last) begin
					idx1++;
					return read_request(PEND_DATA, blk1, idx1);
				end
				if (lvl == LVL_SINGLE) begin
					idx1 = '0;
					idx2 = '0;
					lvl  = LVL_DOUBLE;
					blk2 = inode_ptr[SLOT_DOUBLE];
					return read_request(PEND_L1, blk2, 0);
				end
				if (idx2 < last) begin
					idx1 = '0;
					idx2++;
					return read_request(PEND_L1, blk2, idx2);
				end
				if (lvl == LVL_DOUBLE) begin
					idx1 = '0;
					idx2 = '0;
					idx3 = '0;
					lvl  = LVL_TRIPLE;
					return read_request(PEND_L2, inode_ptr[SLOT_TRIPLE], 0);
				end
				if (idx3 < last) begin
					idx1 = '0;
					idx2 = '0;
					idx3++;
					return read_request(PEND_L2, inode_ptr[SLOT_TRIPLE], idx3);
				end
				// walked off the end of the triple range: position saturates
				return pack_result(ST_RANGE, 0, 0);
			end
			default: begin
				case (awaiting)
					PEND_DATA: begin
						awaiting = PEND_NONE;
						return pack_result(ST_REPORT, it.word, 0);
					end
					PEND_L1: begin
						blk1 = it.word;
						return read_request(PEND_DATA, it.word, idx1);
					end
					PEND_L2: begin
						blk2 = it.word;
						return read_request(PEND_L1, it.word, idx2);
					end
					default: return pack_result(ST_UNEXPECTED, 0, 0);
				endcase
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) inode_ptr[s] = '0;
			clear_walk();
			log2_reg = MIN_ENTRIES_LOG2;
			due_results.delete();
		end else begin
			// retire first so a result can never match an item taken at the same edge
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$error("result transaction with nothing expected: status %0d block_id %0h",
						result.status, result.block_id);
					fail_cnt++;
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_cnt++;
					end
					if (result.block_id !== want.block_id) begin
						$error("block_id: expected %0h, got %0h", want.block_id, result.block_id);
						fail_cnt++;
					end
					if (result.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d", want.word_index,
							result.word_index);
						fail_cnt++;
					end
					if (result.in_file !== want.in_file) begin
						$error("in_file: expected %0d, got %0d", want.in_file, result.in_file);
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) log2_reg = cfg_data;
			if (item_valid && !item_stall) due_results.push_back(next_result(item));
		end
		due_cnt = due_results.size();
	end

endmodule

FILE: dv/indirect_block_map_walker_core_tb.sv
// Top of the block map walker testbench: clock, reset, item and cfg stimulus, result stall.
// Checking lives in indirect_block_map_walker_check; depends on iblw_pkg and the core.
module indirect_block_map_walker_core_tb;
	import iblw_pkg::*;

	localparam int MAX_LOG2      = DEFAULT_MAX_ENTRIES_LOG2;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DIRECT_BLOCKS = LAST_DIRECT + 1;
	localparam int RANDOM_ITEMS  = 140;
	localparam int PHASE_ITEMS   = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	int          fail_count;
	int          in_flight;
	int          idle_pct = 29;
	int          stall_pct = 29;
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          cycle_count = 0;
	int          items_sent = 0;
	int          log2_eff = MIN_ENTRIES_LOG2;
	longint      walk_pos = 0;
	logic [3:0]  log2_choices [7] = '{4'd15, 4'd0, 4'd9, 4'd10, 4'd12, 4'd3, 4'd8};

	indirect_block_map_walker_core #(
		.MAX_ENTRIES_LOG2(MAX_LOG2)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	indirect_block_map_walker_check #(
		.MAX_ENTRIES_LOG2(MAX_LOG2)
	) walk_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.failures(fail_count),
		.in_flight(in_flight)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stall, or a long hold-off once requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_req <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [31:0] pointer_word();
		return ($urandom_range(7) == 0) ? 32'h0 : 32'($urandom);
	endfunction

	// valid stays high after acceptance; the next call or drain() decides what follows
	task automatic send_item(input kind_t k, input logic [3:0] slot, input logic [31:0] w);
		item_t it;
		it.kind = k;
		it.ptr_index = slot;
		it.word = w;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	task automatic write_entries_log2(input logic [3:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		log2_eff = (v < MIN_ENTRIES_LOG2) ? MIN_ENTRIES_LOG2 : (v > MAX_LOG2) ? MAX_LOG2 : v;
	endtask

	task automatic restart();
		send_item(KIND_REWIND, 4'($urandom_range(15)), 32'($urandom));
		walk_pos = 0;
	endtask

	// Advance step by step, answering each read request the new position needs.
	task automatic walk(input int steps, input bit mixed);
		longint e;
		longint t;
		int fetches;
		e = longint'(1) << log2_eff;
		for (int s = 0; s < steps; s++) begin
			send_item(KIND_ADVANCE, 4'($urandom_range(15)), 32'($urandom));
			walk_pos++;
			if (walk_pos < DIRECT_BLOCKS) begin
				fetches = 0;
			end else if (walk_pos < DIRECT_BLOCKS + e) begin
				fetches = 1;
			end else if (walk_pos < DIRECT_BLOCKS + e + e * e) begin
				fetches = ((walk_pos - DIRECT_BLOCKS - e) % e == 0) ? 2 : 1;
			end else begin
				t = walk_pos - DIRECT_BLOCKS - e - e * e;
				fetches = (t % (e * e) == 0) ? 3 : ((t % e == 0) ? 2 : 1);
			end
			repeat (fetches) begin
				if (mixed && $urandom_range(15) == 0)
					send_item(KIND_LOAD, 4'($urandom_range(14)), pointer_word());
				send_item(KIND_RESPONSE, 4'($urandom_range(15)), pointer_word());
			end
		end
	endtask

	initial begin
		int random_start;
		int next_phase;
		int phase;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner values and each odd case of the walk
		send_item(KIND_RESPONSE, 4'd0, 32'hFFFF_FFFF);
		send_item(KIND_ADVANCE, 4'd15, 32'h0);
		send_item(KIND_LOAD, 4'd0, 32'hFFFF_FFFF);
		send_item(KIND_LOAD, 4'd12, 32'h0);
		send_item(KIND_LOAD, 4'd13, 32'h8000_0001);
		send_item(KIND_LOAD, 4'd15, 32'h1234_5678);
		restart();
		walk(DIRECT_BLOCKS - 1, 1'b0);
		send_item(KIND_ADVANCE, 4'd0, 32'h0);
		send_item(KIND_ADVANCE, 4'd0, 32'h0);
		send_item(KIND_LOAD, 4'd14, 32'hFFFF_FFFF);
		send_item(KIND_RESPONSE, 4'd0, 32'h0);
		send_item(KIND_ADVANCE, 4'd0, 32'h0);
		restart();
		send_item(KIND_RESPONSE, 4'd15, 32'hFFFF_FFFF);

		// shrink the block size with index_one beyond the new last entry;
		// the long walk runs with no idling on either side
		write_entries_log2(4'd10);
		restart();
		idle_pct = 0;
		stall_pct <= 0;
		walk(DIRECT_BLOCKS + 261, 1'b0);
		idle_pct = 29;
		stall_pct <= 29;
		write_entries_log2(4'd8);
		send_item(KIND_ADVANCE, 4'd0, 32'h0);
		send_item(KIND_RESPONSE, 4'd0, pointer_word());
		send_item(KIND_RESPONSE, 4'd0, pointer_word());
		restart();

		// receiver holds off while items keep coming, then sender waits for all results
		hold_req <= 1'b1;
		restart();
		walk(40, 1'b1);
		drain();

		random_start = items_sent;
		next_phase = 0;
		phase = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start >= next_phase) begin
				write_entries_log2(log2_choices[phase % 7]);
				restart();
				phase++;
				next_phase += PHASE_ITEMS;
			end
			pick = $urandom_range(99);
			if (pick < 10) begin
				restart();
			end else if (pick < 20) begin
				send_item(KIND_LOAD, 4'($urandom_range(14)), pointer_word());
			end else if (pick < 85) begin
				walk($urandom_range(1, 8), 1'b1);
			end else if (pick < 95) begin
				// arbitrary transaction, then resync the walk
				send_item(kind_t'($urandom_range(3)), 4'($urandom_range(15)), 32'($urandom));
				restart();
			end else begin
				drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
